FILE: rtl/dns_query_to_response_rewriter_core_assert.svh
// Assertion macros shared by the rewriter RTL.
// The enclosing module must provide the signals clock and reset.
`ifndef DNS_QUERY_TO_RESPONSE_REWRITER_CORE_ASSERT_SVH
`define DNS_QUERY_TO_RESPONSE_REWRITER_CORE_ASSERT_SVH

// Checked at every clock edge outside reset.
`define DQR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define DQR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/dqr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqr_pkg
// Shared types and constants of the DNS query to response rewriter.
// ----------------------------------------------------------------------------
package dqr_pkg;

   localparam int MAX_FRAME_BYTES_DEFAULT = 512;
   localparam int QUEUE_DEPTH_DEFAULT     = 4;

   localparam logic [31:0] TTL_RESET   = 32'h0101_0101;
   localparam logic [7:0]  QR_RA_MASK  = 8'b1000_0000;
   localparam logic [7:0]  PTR_HI      = 8'hc0;
   localparam logic [7:0]  PTR_LO      = 8'h0c;
   localparam logic [7:0]  DOT_CHAR    = 8'h2e;
   localparam logic [3:0]  ANSWER_LAST = 4'd15;

   typedef struct packed {
      logic [7:0]  in_byte;
      logic        in_last;
      logic [31:0] answer_ip;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_last;
      logic [7:0]  name_char;
      logic        name_valid;
      logic [15:0] query_type;
      logic [15:0] question_class;
      logic        question_done;
   } rsp_item_type;

   // One classified byte on its way from the front to the back.
   typedef struct packed {
      rsp_item_type echo;
      logic         msg_last;
      logic [31:0]  answer_ip;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: rtl/dqr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqr_queue
// Small register queue between the parsing front and the response back.
// ----------------------------------------------------------------------------
`include "dns_query_to_response_rewriter_core_assert.svh"

module dqr_queue #(
   parameter int DEPTH = dqr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  dqr_pkg::queue_entry_type  push_data,
   input  logic                      pop,
   output dqr_pkg::queue_entry_type  pop_data,
   output dqr_pkg::queue_status_type status
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   dqr_pkg::queue_entry_type slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CntW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `DQR_ASSERT(a_no_push_when_full, !(push && status.full), "queue written while full")
   `DQR_ASSERT(a_no_pop_when_empty, !(pop && status.empty), "queue read while empty")

endmodule

FILE: rtl/dqr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqr_front
// Accepts query bytes, rewrites the header and parses the question section.
// ----------------------------------------------------------------------------
module dqr_front #(
   parameter int MAX_FRAME_BYTES = dqr_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  dqr_pkg::req_item_type     req_data,
   input  dqr_pkg::queue_status_type status,
   output logic                      push,
   output dqr_pkg::queue_entry_type  push_data
);

   localparam int PosW = $clog2(MAX_FRAME_BYTES);

   typedef enum logic [4:0] {
      PH_HEADER    = 5'b00001,
      PH_FIRSTLEN  = 5'b00010,
      PH_NAME      = 5'b00100,
      PH_TYPECLASS = 5'b01000,
      PH_DONE      = 5'b10000
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [5:0]      label_ff, label_in;
   logic [23:0]     tc_shift_ff, tc_shift_in;
   logic [1:0]      tc_count_ff, tc_count_in;
   logic            accept;
   logic [7:0]      b;

   assign req_stall = status.full;
   assign accept    = req_valid && !status.full;
   assign push      = accept;
   assign b         = req_data.in_byte;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      label_in    = label_ff;
      tc_shift_in = tc_shift_ff;
      tc_count_in = tc_count_ff;

      push_data           = '0;
      push_data.msg_last  = req_data.in_last;
      push_data.answer_ip = req_data.answer_ip;

      push_data.echo.out_byte = b;
      if (pos_ff == PosW'(2) || pos_ff == PosW'(3)) begin
         push_data.echo.out_byte = b | dqr_pkg::QR_RA_MASK;
      end
      if (pos_ff == PosW'(7)) begin
         push_data.echo.out_byte = 8'd1;
      end

      unique case (phase_ff)
         PH_HEADER: begin
            if (pos_ff >= PosW'(11)) begin
               phase_in = PH_FIRSTLEN;
            end
         end
         PH_FIRSTLEN: begin
            if (b == 8'd0) begin
               phase_in = PH_TYPECLASS;
            end else begin
               label_in = b[5:0];
               phase_in = PH_NAME;
            end
         end
         PH_NAME: begin
            if (label_ff != 6'd0) begin
               push_data.echo.name_char  = b;
               push_data.echo.name_valid = 1'b1;
               label_in                  = label_ff - 6'd1;
            end else if (b == 8'd0) begin
               phase_in = PH_TYPECLASS;
            end else begin
               // A boundary byte starts the next label and shows as a dot.
               push_data.echo.name_char  = dqr_pkg::DOT_CHAR;
               push_data.echo.name_valid = 1'b1;
               label_in                  = b[5:0];
            end
         end
         PH_TYPECLASS: begin
            tc_shift_in = {tc_shift_ff[15:0], b};
            if (tc_count_ff == 2'd3) begin
               push_data.echo.query_type     = tc_shift_ff[23:8];
               push_data.echo.question_class = {tc_shift_ff[7:0], b};
               push_data.echo.question_done  = 1'b1;
               tc_count_in                   = 2'd0;
               phase_in                      = PH_DONE;
            end else begin
               tc_count_in = tc_count_ff + 2'd1;
            end
         end
         PH_DONE: begin
         end
         default: begin
            phase_in = PH_HEADER;
         end
      endcase

      if (pos_ff < PosW'(MAX_FRAME_BYTES - 1)) begin
         pos_in = pos_ff + PosW'(1);
      end

      // The last byte of a message returns the parser to its start.
      if (req_data.in_last) begin
         phase_in    = PH_HEADER;
         pos_in      = '0;
         label_in    = '0;
         tc_shift_in = '0;
         tc_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         pos_ff      <= '0;
         label_ff    <= '0;
         tc_shift_ff <= '0;
         tc_count_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         label_ff    <= label_in;
         tc_shift_ff <= tc_shift_in;
         tc_count_ff <= tc_count_in;
      end
   end

endmodule

FILE: rtl/dqr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqr_back
// Sends echoed bytes and appends the 16-byte answer record after each message.
// ----------------------------------------------------------------------------
`include "dns_query_to_response_rewriter_core_assert.svh"

module dqr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [31:0]               csr_write_data,
   input  dqr_pkg::queue_status_type status,
   input  dqr_pkg::queue_entry_type  pop_data,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dqr_pkg::rsp_item_type     rsp_data
);

   logic [31:0]           ttl_ff;
   logic [31:0]           ip_ff, ip_in;
   logic                  busy_ff, busy_in;
   logic [3:0]            idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   dqr_pkg::rsp_item_type data_ff, data_in;
   logic                  load;
   logic [7:0]            ans_byte;

   assign load      = !valid_ff || !rsp_stall;
   assign pop       = load && !busy_ff && !status.empty;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      unique case (idx_ff)
         4'd0:    ans_byte = dqr_pkg::PTR_HI;
         4'd1:    ans_byte = dqr_pkg::PTR_LO;
         4'd2:    ans_byte = 8'd0;
         4'd3:    ans_byte = 8'd1;
         4'd4:    ans_byte = 8'd0;
         4'd5:    ans_byte = 8'd1;
         4'd6:    ans_byte = ttl_ff[31:24];
         4'd7:    ans_byte = ttl_ff[23:16];
         4'd8:    ans_byte = ttl_ff[15:8];
         4'd9:    ans_byte = ttl_ff[7:0];
         4'd10:   ans_byte = 8'd0;
         4'd11:   ans_byte = 8'd4;
         4'd12:   ans_byte = ip_ff[31:24];
         4'd13:   ans_byte = ip_ff[23:16];
         4'd14:   ans_byte = ip_ff[15:8];
         default: ans_byte = ip_ff[7:0];
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      ip_in    = ip_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         if (busy_ff) begin
            valid_in          = 1'b1;
            data_in           = '0;
            data_in.out_byte  = ans_byte;
            data_in.out_last  = (idx_ff == dqr_pkg::ANSWER_LAST);
            idx_in            = idx_ff + 4'd1;
            busy_in           = (idx_ff != dqr_pkg::ANSWER_LAST);
         end else if (!status.empty) begin
            valid_in = 1'b1;
            data_in  = pop_data.echo;
            if (pop_data.msg_last) begin
               busy_in = 1'b1;
               idx_in  = 4'd0;
               ip_in   = pop_data.answer_ip;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff   <= dqr_pkg::TTL_RESET;
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            ttl_ff <= csr_write_data;
         end
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ip_ff   <= ip_in;
      data_ff <= data_in;
   end

   `DQR_ASSERT(a_last_ends_answer, (load && busy_ff && idx_ff == dqr_pkg::ANSWER_LAST) |=> (valid_ff && data_ff.out_last && !busy_ff), "answer record did not end with a last byte")
   `DQR_ASSERT(a_last_is_clean, (valid_ff && data_ff.out_last) |-> (!data_ff.name_valid && !data_ff.question_done && !busy_ff), "last byte carries parse fields or answer still open")
   `DQR_ASSERT_ALWAYS(a_reset_idle, reset |=> (!valid_ff && !busy_ff), "response side not idle after reset")

endmodule

FILE: rtl/dns_query_to_response_rewriter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_to_response_rewriter_core
// Turns a DNS query byte stream into a response with one appended A record.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes one query byte per transfer, with in_last on the
// final byte and answer_ip valid alongside it. The rsp channel returns one
// response byte per transfer: each query byte echoed with QR and RA set and
// the answer count low byte forced to 1, plus the question name characters
// and, on the completing byte, the query type and class. After the echo of
// the last byte, 16 answer bytes follow, the final one with out_last set.
// csr_write_data sets the answer TTL and may be written only while idle.
// Each req byte passes the queue and then the output register on its way to
// rsp. Both sides run at one transfer per cycle unless a stall holds them; a
// message of N bytes yields N + 16 response bytes, and the four-entry queue
// between parser and output absorbs the answer burst until it fills, when
// req_stall rises. A stall on rsp holds the output register and backs up into
// the queue. Reset clears parser, queue and output, loads the TTL with 0x01010101.
// ----------------------------------------------------------------------------
module dns_query_to_response_rewriter_core #(
   parameter int MAX_FRAME_BYTES = dqr_pkg::MAX_FRAME_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH     = dqr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dqr_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dqr_pkg::rsp_item_type rsp_data,
   input  logic                  csr_write_enable,
   input  logic [31:0]           csr_write_data
);

   dqr_pkg::queue_status_type status;
   dqr_pkg::queue_entry_type  push_data;
   dqr_pkg::queue_entry_type  pop_data;
   logic                      push;
   logic                      pop;

   dqr_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .status    (status),
      .push      (push),
      .push_data (push_data)
   );

   dqr_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (status)
   );

   dqr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .pop_data         (pop_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

FILE: verif/dns_query_to_response_rewriter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_to_response_rewriter_core_test
// Drives DNS query byte streams through the rewriter and checks every
// response transfer, field by field, against a cycle-free behavioral
// predictor. A short directed table runs first, then random well-formed
// queries, truncated queries, noise and one oversize message, under three
// TTL settings and with random idling on both channels.
// ----------------------------------------------------------------------------
module dns_query_to_response_rewriter_core_test;

   localparam int          CLOCK_HALF   = 10;
   localparam int          CYCLE_LIMIT  = 1000000;
   // A short frame limit lets a modest message run past the position ceiling.
   localparam int          FRAME_BYTES  = 40;
   localparam logic [15:0] RR_TYPE_A    = 16'h0001;
   localparam logic [15:0] RR_CLASS_IN  = 16'h0001;
   localparam logic [15:0] RDLENGTH_V4  = 16'h0004;
   localparam int          HEADER_BYTES = 12;

   typedef enum logic [4:0] {
      PH_HEADER     = 5'b00001,
      PH_FIRST_LEN  = 5'b00010,
      PH_NAME       = 5'b00100,
      PH_TYPE_CLASS = 5'b01000,
      PH_DONE       = 5'b10000
   } parse_phase_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [31:0] ip;
      logic        typed;
      logic [7:0]  want;
   } directed_row_type;

   // Header rewrites, a length byte with high bits set, a zero-length
   // label, a zero character inside a label, then a short message.
   localparam directed_row_type DIRECTED_ROWS [25] = '{
      '{8'h00, 1'b0, 32'h0, 1'b1, 8'h00},
      '{8'hff, 1'b0, 32'h0, 1'b1, 8'hff},
      '{8'h00, 1'b0, 32'h0, 1'b1, 8'h80},
      '{8'h7f, 1'b0, 32'h0, 1'b1, 8'hff},
      '{8'h00, 1'b0, 32'h0, 1'b1, 8'h00},
      '{8'h01, 1'b0, 32'h0, 1'b1, 8'h01},
      '{8'hff, 1'b0, 32'h0, 1'b1, 8'hff},
      '{8'hff, 1'b0, 32'h0, 1'b1, 8'h01},
      '{8'h00, 1'b0, 32'h0, 1'b1, 8'h00},
      '{8'h00, 1'b0, 32'h0, 1'b1, 8'h00},
      '{8'h00, 1'b0, 32'h0, 1'b1, 8'h00},
      '{8'h00, 1'b0, 32'h0, 1'b1, 8'h00},
      '{8'h41, 1'b0, 32'h0, 1'b0, 8'h00},
      '{8'h61, 1'b0, 32'h0, 1'b0, 8'h00},
      '{8'h40, 1'b0, 32'h0, 1'b0, 8'h00},
      '{8'h01, 1'b0, 32'h0, 1'b0, 8'h00},
      '{8'h00, 1'b0, 32'h0, 1'b0, 8'h00},
      '{8'h00, 1'b0, 32'h0, 1'b0, 8'h00},
      '{8'h00, 1'b0, 32'h0, 1'b0, 8'h00},
      '{8'h01, 1'b0, 32'h0, 1'b0, 8'h00},
      '{8'h00, 1'b0, 32'h0, 1'b0, 8'h00},
      '{8'hff, 1'b1, 32'hffff_ffff, 1'b0, 8'h00},
      '{8'hff, 1'b0, 32'h0, 1'b1, 8'hff},
      '{8'h80, 1'b0, 32'h0, 1'b1, 8'h80},
      '{8'h00, 1'b1, 32'h0, 1'b1, 8'h80}
   };

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   dqr_pkg::req_item_type req_data         = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   dqr_pkg::rsp_item_type rsp_data;
   logic                  csr_write_enable = 1'b0;
   logic [31:0]           csr_write_data   = '0;

   // Predictor state.
   logic [31:0]     answer_ttl      = dqr_pkg::TTL_RESET;
   logic [9:0]      byte_pos        = '0;
   parse_phase_type phase           = PH_HEADER;
   logic [5:0]      label_left      = '0;
   logic [31:0]     type_class_bits = '0;
   logic [1:0]      type_class_seen = '0;

   dqr_pkg::rsp_item_type response_q [$];
   logic [7:0]            query_bytes [$];
   int                    failures      = 0;
   int                    cycles        = 0;
   int                    rsp_count     = 0;
   int                    sender_calm   = 0;
   int                    receiver_calm = 0;
   int                    stall_left    = 0;
   bit                    hold_done     = 1'b0;

   dns_query_to_response_rewriter_core #(
      .MAX_FRAME_BYTES(FRAME_BYTES)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, response_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic predict_response(input dqr_pkg::req_item_type it, input logic typed,
                                   input logic [7:0] want);
      dqr_pkg::rsp_item_type r;
      logic [127:0] answer;
      r = '0;
      r.out_byte = it.in_byte;
      if (byte_pos == 10'd2 || byte_pos == 10'd3) begin
         r.out_byte = r.out_byte | dqr_pkg::QR_RA_MASK;
      end
      if (byte_pos == 10'd7) r.out_byte = 8'd1;
      case (phase)
         PH_HEADER: begin
            if (byte_pos >= HEADER_BYTES - 1) phase = PH_FIRST_LEN;
         end
         PH_FIRST_LEN: begin
            if (it.in_byte == 8'd0) begin
               phase = PH_TYPE_CLASS;
            end else begin
               label_left = it.in_byte[5:0];
               phase = PH_NAME;
            end
         end
         PH_NAME: begin
            if (label_left != 0) begin
               r.name_char = it.in_byte;
               r.name_valid = 1'b1;
               label_left = label_left - 1;
            end else if (it.in_byte == 8'd0) begin
               phase = PH_TYPE_CLASS;
            end else begin
               r.name_char = dqr_pkg::DOT_CHAR;
               r.name_valid = 1'b1;
               label_left = it.in_byte[5:0];
            end
         end
         PH_TYPE_CLASS: begin
            type_class_bits = {type_class_bits[23:0], it.in_byte};
            if (type_class_seen == 2'd3) begin
               r.query_type = type_class_bits[31:16];
               r.question_class = type_class_bits[15:0];
               r.question_done = 1'b1;
               type_class_seen = '0;
               phase = PH_DONE;
            end else begin
               type_class_seen = type_class_seen + 1;
            end
         end
         default: ;
      endcase
      if (byte_pos < FRAME_BYTES - 1) byte_pos = byte_pos + 1;
      if (typed) r.out_byte = want;
      response_q.push_back(r);
      if (it.in_last) begin
         answer = {dqr_pkg::PTR_HI, dqr_pkg::PTR_LO, RR_TYPE_A, RR_CLASS_IN,
                   answer_ttl, RDLENGTH_V4, it.answer_ip};
         for (int k = 0; k < 16; k++) begin
            r = '0;
            r.out_byte = answer[127 - 8 * k -: 8];
            r.out_last = (k == dqr_pkg::ANSWER_LAST);
            response_q.push_back(r);
         end
         byte_pos = '0;
         phase = PH_HEADER;
         label_left = '0;
         type_class_bits = '0;
         type_class_seen = '0;
      end
   endtask

   // Called at a rising edge; returns at the edge of the transfer.
   task automatic drive_byte(input dqr_pkg::req_item_type it, input logic typed,
                             input logic [7:0] want);
      int gap;
      if (sender_calm > 0) begin
         sender_calm--;
         gap = 0;
      end else if ($urandom_range(0, 39) == 0) begin
         sender_calm = $urandom_range(20, 60);
         gap = 0;
      end else begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_response(it, typed, want);
   endtask

   task automatic send_message();
      dqr_pkg::req_item_type it;
      for (int i = 0; i < query_bytes.size(); i++) begin
         it.in_byte = query_bytes[i];
         it.in_last = (i == query_bytes.size() - 1);
         it.answer_ip = $urandom;
         drive_byte(it, 1'b0, 8'h00);
      end
   endtask

   task automatic build_query();
      int labels;
      int len;
      logic [1:0] top;
      query_bytes.delete();
      repeat (HEADER_BYTES) query_bytes.push_back(8'($urandom_range(0, 255)));
      labels = $urandom_range(0, 3);
      repeat (labels) begin
         if ($urandom_range(0, 9) == 0) len = 0;
         else if ($urandom_range(0, 19) == 0) len = 63;
         else len = $urandom_range(1, 6);
         top = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
         // A zero length byte would end the name, so an empty label needs high bits.
         if (len == 0 && top == 2'b00) top = 2'($urandom_range(1, 3));
         query_bytes.push_back({top, 6'(len)});
         repeat (len) query_bytes.push_back(8'($urandom_range(0, 255)));
      end
      query_bytes.push_back(8'h00);
      repeat (4) query_bytes.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) query_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic run_random(input int item_goal, input bit with_oversize);
      int sent;
      int kind;
      int keep;
      sent = 0;
      if (with_oversize) begin
         build_query();
         while (query_bytes.size() < FRAME_BYTES + 13)
            query_bytes.push_back(8'($urandom_range(0, 255)));
         send_message();
      end
      while (sent < item_goal) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            build_query();
         end else if (kind < 9) begin
            build_query();
            keep = $urandom_range(1, query_bytes.size() - 1);
            while (query_bytes.size() > keep) void'(query_bytes.pop_back());
         end else begin
            query_bytes.delete();
            repeat ($urandom_range(1, 30)) query_bytes.push_back(8'($urandom_range(0, 255)));
         end
         send_message();
         sent += query_bytes.size();
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (response_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_ttl(input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      answer_ttl = value;
   endtask

   task automatic check_field(input string label, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, label, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      dqr_pkg::rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (response_q.size() == 0) begin
               $display("%0t: response transfer with nothing expected, got %h", $time,
                        rsp_data);
               failures++;
            end else begin
               want = response_q.pop_front();
               check_field("out_byte", want.out_byte, rsp_data.out_byte);
               check_field("out_last", want.out_last, rsp_data.out_last);
               check_field("name_char", want.name_char, rsp_data.name_char);
               check_field("name_valid", want.name_valid, rsp_data.name_valid);
               check_field("query_type", want.query_type, rsp_data.query_type);
               check_field("question_class", want.question_class,
                           rsp_data.question_class);
               check_field("question_done", want.question_done, rsp_data.question_done);
            end
         end
         // One long hold while the sender is busy, so the queue fills and
         // the input side has to stall.
         if (!hold_done && rsp_count >= 100 && req_valid) begin
            stall_left = 120;
            hold_done = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (receiver_calm > 0) receiver_calm--;
            else if ($urandom_range(0, 49) == 0) receiver_calm = $urandom_range(20, 60);
            else stall_left = pick_gap();
         end
      end
   end

   initial begin
      dqr_pkg::req_item_type it;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_ROWS[i]) begin
         it.in_byte = DIRECTED_ROWS[i].data;
         it.in_last = DIRECTED_ROWS[i].last;
         it.answer_ip = DIRECTED_ROWS[i].ip;
         drive_byte(it, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
      drain();
      write_ttl(32'h0000_0000);
      run_random(55, 1'b0);
      drain();
      write_ttl(32'hffff_ffff);
      run_random(45, 1'b1);
      drain();
      write_ttl($urandom);
      run_random(55, 1'b0);
      drain();
      repeat (8) @(posedge clock);
      if (failures == 0 && response_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
